/* rtl/atd_pkg.sv */
// Shared types and constants for the accelerometer tap detector.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps

package atd_pkg;

	// Sample and index widths
	localparam int SAMPLE_BITS = 12;
	localparam int INDEX_BITS  = 32;

	// Squared axis (always non-negative) and squared magnitude widths
	localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
	localparam int MAG_W = 2 * SAMPLE_BITS + 1;

	// Configuration register widths
	localparam int THR_W  = 24;
	localparam int LOOK_W = 8;
	localparam int SKIP_W = 8;
	localparam int HOLD_W = 16;

	// Compare width covers both the magnitude and the threshold
	localparam int CMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;

	// Stream packing
	localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((INDEX_BITS + 7) / 8) * 8;

	// APB port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_LOOKAHEAD = 2'd1;
	localparam logic [1:0] REG_SKIP      = 2'd2;
	localparam logic [1:0] REG_HOLDOFF   = 2'd3;

	// Register reset values
	localparam logic [THR_W-1:0]  RST_THRESHOLD = '0;
	localparam logic [LOOK_W-1:0] RST_LOOKAHEAD = LOOK_W'(8);
	localparam logic [SKIP_W-1:0] RST_SKIP      = SKIP_W'(4);
	localparam logic [HOLD_W-1:0] RST_HOLDOFF   = '0;

	// Samples skipped after the first dip arms the wait
	localparam logic [SKIP_W-1:0] ARM_SKIP = SKIP_W'(2);

	// Dip queue between classifier and tap sequencer
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Tap sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_WAIT
	} tap_state_t;

	// Configuration register bundle
	typedef struct packed {
		logic [THR_W-1:0]  threshold_sq;
		logic [LOOK_W-1:0] look_limit;
		logic [SKIP_W-1:0] skip_len;
		logic [HOLD_W-1:0] holdoff_samples;
	} cfg_t;

endpackage

/* rtl/atd_cfg_regs.sv */
// APB register file for the tap detector: threshold, lookahead, skip, holdoff.
// Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_cfg_regs import atd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_sq    <= RST_THRESHOLD;
			cfg_q.look_limit      <= RST_LOOKAHEAD;
			cfg_q.skip_len        <= RST_SKIP;
			cfg_q.holdoff_samples <= RST_HOLDOFF;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_THRESHOLD: cfg_q.threshold_sq    <= pwdata[THR_W-1:0];
				REG_LOOKAHEAD: cfg_q.look_limit      <= pwdata[LOOK_W-1:0];
				REG_SKIP:      cfg_q.skip_len        <= pwdata[SKIP_W-1:0];
				REG_HOLDOFF:   cfg_q.holdoff_samples <= pwdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = APB_DW'(cfg_q.threshold_sq);
			REG_LOOKAHEAD: prdata = APB_DW'(cfg_q.look_limit);
			REG_SKIP:      prdata = APB_DW'(cfg_q.skip_len);
			REG_HOLDOFF:   prdata = APB_DW'(cfg_q.holdoff_samples);
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/atd_front.sv */
// Front end: squares the three axes, sums them and flags a dip below threshold.
// Two stages: multipliers into _s1 registers, then add and compare. Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_front import atd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_take,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic [THR_W-1:0]              threshold_sq,
	output logic                          busy,
	output logic                          push,
	output logic                          dip
);

	logic signed [2*SAMPLE_BITS-1:0] px, py, pz;
	logic [SQ_W-1:0]                 sqx_s1, sqy_s1, sqz_s1;
	logic                            valid_s1;
	logic [CMP_W-1:0]                mag;

	// Per-axis squares; results are non-negative and fit SQ_W bits
	assign px = accel_x * accel_x;
	assign py = accel_y * accel_y;
	assign pz = accel_z * accel_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sqx_s1 <= px[SQ_W-1:0];
			sqy_s1 <= py[SQ_W-1:0];
			sqz_s1 <= pz[SQ_W-1:0];
		end
	end

	// Magnitude sum and threshold compare
	assign mag  = CMP_W'(sqx_s1) + CMP_W'(sqy_s1) + CMP_W'(sqz_s1);
	assign dip  = mag < CMP_W'(threshold_sq);
	assign push = valid_s1;
	assign busy = valid_s1;

endmodule

/* rtl/atd_queue.sv */
// Short FIFO of dip flags between the classifier and the tap sequencer.
// Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_queue import atd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              push_dip,
	input  logic              pop,
	output logic              head_valid,
	output logic              head_dip,
	output logic [QCNT_W-1:0] count
);

	logic [QUEUE_DEPTH-1:0] mem_q;
	logic [QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]      count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_dip;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'((QPTR_W + 1)'(wr_ptr_q) + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'((QPTR_W + 1)'(rd_ptr_q) + 1'b1);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_valid = (count_q != '0);
	assign head_dip   = mem_q[rd_ptr_q];
	assign count      = count_q;

`ifndef SYNTHESIS
	// No push into a full queue without a pop in the same cycle, no pop from an empty one
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_W'(QUEUE_DEPTH)) || pop)
		else $error("dip queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("dip queue underflow");
`endif

endmodule

/* rtl/atd_back.sv */
// Back end: tap sequencer with holdoff, skip and lookahead counters, and the result register.
// Consumes one dip flag per cycle when the result register can take a report. Depends on atd_pkg.
`timescale 1ns / 1ps

module atd_back import atd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  head_valid,
	input  logic                  head_dip,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_double,
	output logic [INDEX_BITS-1:0] out_index
);

	tap_state_t            state_q, state_d;
	logic [SKIP_W-1:0]     skip_q, skip_d;
	logic [LOOK_W-1:0]     look_q, look_d;
	logic [HOLD_W-1:0]     hold_q, hold_d;
	logic [INDEX_BITS-1:0] count_q, count_d;
	logic [INDEX_BITS-1:0] first_q, first_d;
	logic [INDEX_BITS-1:0] count_inc;
	logic [LOOK_W-1:0]     look_inc;
	logic                  report, rep_double;
	logic [INDEX_BITS-1:0] rep_index;
	logic                  out_valid_q, out_double_q;
	logic [INDEX_BITS-1:0] out_index_q;

	// Take the next flag whenever the result slot is free or draining
	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign count_inc = count_q + 1'b1;
	assign look_inc  = look_q + 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		if (pop && hold_q == '0 && skip_q == '0) begin
			unique case (state_q)
				ST_IDLE: if (head_dip) state_d = ST_WAIT;
				ST_WAIT: if (head_dip || look_inc >= cfg.look_limit) state_d = ST_IDLE;
				default: state_d = ST_IDLE;
			endcase
		end
	end

	// Counters and report
	always_comb begin
		skip_d     = skip_q;
		look_d     = look_q;
		hold_d     = hold_q;
		count_d    = count_q;
		first_d    = first_q;
		report     = 1'b0;
		rep_double = 1'b0;
		rep_index  = first_q;
		if (pop) begin
			if (hold_q != '0) begin
				// dropped sample, not counted
				hold_d = hold_q - 1'b1;
			end else begin
				count_d = count_inc;
				if (skip_q != '0) begin
					skip_d = skip_q - 1'b1;
				end else begin
					unique case (state_q)
						ST_IDLE: begin
							if (head_dip) begin
								look_d  = '0;
								first_d = count_inc;
								skip_d  = ARM_SKIP;
							end
						end
						ST_WAIT: begin
							look_d = look_inc;
							if (head_dip) begin
								report     = 1'b1;
								rep_double = 1'b1;
								rep_index  = count_inc;
							end else if (look_inc >= cfg.look_limit) begin
								report    = 1'b1;
								rep_index = first_q;
							end
						end
						default: ;
					endcase
					if (report) begin
						skip_d = cfg.skip_len;
						hold_d = cfg.holdoff_samples;
					end
				end
			end
		end
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			skip_q  <= '0;
			look_q  <= '0;
			hold_q  <= '0;
			count_q <= '0;
			first_q <= '0;
		end else begin
			state_q <= state_d;
			skip_q  <= skip_d;
			look_q  <= look_d;
			hold_q  <= hold_d;
			count_q <= count_d;
			first_q <= first_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			out_double_q <= rep_double;
			out_index_q  <= rep_index;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_double = out_double_q;
	assign out_index  = out_index_q;

`ifndef SYNTHESIS
	// A report never overwrites a result that is still waiting
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		report |-> !out_valid_q || out_ready)
		else $error("result overwritten");
	// While waiting for a second dip only the arming skip can be pending
	a_wait_counters: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> skip_q <= ARM_SKIP && hold_q == '0)
		else $error("counters inconsistent in wait state");
	// Every report returns the sequencer to idle
	a_report_idle: assert property (@(posedge clk) disable iff (!arst_n)
		report |=> state_q == ST_IDLE)
		else $error("sequencer not idle after report");
`endif

endmodule

/* rtl/accel_tap_detector.sv */
// Top level of the accelerometer tap detector: APB registers, classifier, dip queue, sequencer.
// Depends on atd_pkg, atd_cfg_regs, atd_front, atd_queue, atd_back.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    tdata: accel_x, accel_y, accel_z
//  m_*       out  m_tvalid / m_tready    tdata: tap_index; tuser: is_double
//  apb       in   psel, penable, pready  4 registers at byte address 4*i
//
// One sample per cycle sustained while m_* is not stalled. An accepted sample is registered
// in the multiplier stage, then added, compared and written into the dip queue for the
// sequencer; a report appears in m_* the cycle after the sequencer takes its flag.
// Reset is asynchronous, active low; registers return to 0, 8, 4, 0.
// A stall on m_* stops the sequencer; the four-entry queue then fills and s_tready drops.
`timescale 1ns / 1ps

module accel_tap_detector import atd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// sample in: [11:0] accel_x, [23:12] accel_y, [35:24] accel_z, rest zero
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// tap out: [31:0] tap_index
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// tap out: [0] is_double
	output logic [0:0]             m_tuser,
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	cfg_t                  cfg;
	logic                  in_take;
	logic                  front_busy, push, dip;
	logic                  pop, head_valid, head_dip;
	logic [QCNT_W-1:0]     q_count;
	logic                  out_double;
	logic [INDEX_BITS-1:0] out_index;

	atd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Accept only while the queue has room for everything in flight
	assign s_tready = (QCNT_W'(q_count + QCNT_W'(front_busy)) < QCNT_W'(QUEUE_DEPTH));
	assign in_take  = s_tvalid & s_tready;

	atd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_take      (in_take),
		.accel_x      (s_tdata[SAMPLE_BITS-1:0]),
		.accel_y      (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.accel_z      (s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
		.threshold_sq (cfg.threshold_sq),
		.busy         (front_busy),
		.push         (push),
		.dip          (dip)
	);

	atd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_dip   (dip),
		.pop        (pop),
		.head_valid (head_valid),
		.head_dip   (head_dip),
		.count      (q_count)
	);

	atd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_dip   (head_dip),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_double (out_double),
		.out_index  (out_index)
	);

	assign m_tdata = OUT_TDATA_W'(out_index);
	assign m_tuser = out_double;

endmodule
